FILE: hdl/npos_pkg.sv
// ----------------------------------------------------------------------------
// npos_pkg
// Shared widths and request/response types for the nearest point unit.
// ----------------------------------------------------------------------------
package npos_pkg;

  localparam int CoordW = 32;
  localparam int TFrac  = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 2;
  localparam int TW     = TFrac + 1;
  localparam int MulW   = DiffW + TW + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [MulW-1:0]   mul_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } req_t;

  typedef struct packed {
    coord_t nearest_x;
    coord_t nearest_y;
    coord_t nearest_z;
    logic   degenerate;
  } rsp_t;

endpackage

FILE: hdl/nearest_point_on_segment_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_on_segment_unit
// Nearest point on a 3D segment, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  request | req_valid / req_stall     | req  (segment start, end, query)
//  response| rsp_valid / rsp_stall     | rsp  (nearest point, degenerate)
//
//  One request per cycle unless a valid response is stalled; TFrac + 6 register stages.
//  The depth is set by the restoring divider, one quotient bit per stage.
//  Synchronous reset empties the pipeline.
//  A stalled response freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
module nearest_point_on_segment_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  npos_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output npos_pkg::rsp_t  rsp
);

  localparam int T = npos_pkg::TFrac;

  typedef struct packed {
    npos_pkg::coord_t [2:0] s;
    npos_pkg::diff_t  [2:0] d;
    logic                   degen;
  } geo_t;

  typedef struct packed {
    geo_t                    g;
    logic [npos_pkg::SumW-1:0] len2;
    logic [npos_pkg::SumW-1:0] r;
    logic [T-1:0]            q;
    logic                    zero;
    logic                    one;
  } div_t;

  logic adv;
  logic [T+5:0] vld;

  npos_pkg::coord_t [2:0] st, en, qp;
  geo_t                   g1, g2, g3;
  npos_pkg::diff_t  [2:0] e1;
  npos_pkg::prod_t  [2:0] pde, pdd;
  npos_pkg::sum_t         dot, len2;
  div_t                   dv [0:T];
  geo_t                   gm;
  npos_pkg::mul_t   [2:0] m;
  logic [npos_pkg::TW-1:0] t_val;

  assign adv       = !vld[T+5] || !rsp_stall;
  assign req_stall = !adv;
  assign rsp_valid = vld[T+5];

  assign st = {req.start_z, req.start_y, req.start_x};
  assign en = {req.end_z, req.end_y, req.end_x};
  assign qp = {req.query_z, req.query_y, req.query_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T+4:0], req_valid};
    end
  end

  // differences
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        g1.s[a] <= st[a];
        g1.d[a] <= npos_pkg::DiffW'(en[a]) - npos_pkg::DiffW'(st[a]);
        e1[a]   <= npos_pkg::DiffW'(qp[a]) - npos_pkg::DiffW'(st[a]);
      end
      g1.degen <= (st == en);
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv) begin
      g2 <= g1;
      for (int a = 0; a < 3; a++) begin
        pde[a] <= g1.d[a] * e1[a];
        pdd[a] <= g1.d[a] * g1.d[a];
      end
    end
  end

  // sums
  always_ff @(posedge clk) begin
    if (adv) begin
      g3   <= g2;
      dot  <= npos_pkg::SumW'(pde[0]) + npos_pkg::SumW'(pde[1]) + npos_pkg::SumW'(pde[2]);
      len2 <= npos_pkg::SumW'(pdd[0]) + npos_pkg::SumW'(pdd[1]) + npos_pkg::SumW'(pdd[2]);
    end
  end

  // classify
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].g    <= g3;
      dv[0].len2 <= len2;
      dv[0].r    <= dot;
      dv[0].q    <= '0;
      dv[0].zero <= g3.degen || dot[npos_pkg::SumW-1] || (dot == '0);
      dv[0].one  <= !dot[npos_pkg::SumW-1] && ($unsigned(dot) >= $unsigned(len2));
    end
  end

  // divide, one quotient bit per stage
  for (genvar k = 0; k < T; k++) begin : g_div
    logic [npos_pkg::SumW:0] r2;
    logic                    ge;
    assign r2 = {dv[k].r, 1'b0};
    assign ge = r2 >= {1'b0, dv[k].len2};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1].g    <= dv[k].g;
        dv[k+1].len2 <= dv[k].len2;
        dv[k+1].zero <= dv[k].zero;
        dv[k+1].one  <= dv[k].one;
        dv[k+1].r    <= ge ? npos_pkg::SumW'(r2 - {1'b0, dv[k].len2})
                           : npos_pkg::SumW'(r2);
        dv[k+1].q    <= {dv[k].q[T-2:0], ge};
      end
    end
  end

  always_comb begin
    if (dv[T].zero) begin
      t_val = '0;
    end else if (dv[T].one) begin
      t_val = npos_pkg::TW'(1) << T;
    end else begin
      t_val = {1'b0, dv[T].q};
    end
  end

  // scale
  always_ff @(posedge clk) begin
    if (adv) begin
      gm <= dv[T].g;
      for (int a = 0; a < 3; a++) begin
        m[a] <= dv[T].g.d[a] * $signed({1'b0, t_val});
      end
    end
  end

  // offset from start
  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.nearest_x  <= gm.s[0] + npos_pkg::CoordW'(m[0] >>> T);
      rsp.nearest_y  <= gm.s[1] + npos_pkg::CoordW'(m[1] >>> T);
      rsp.nearest_z  <= gm.s[2] + npos_pkg::CoordW'(m[2] >>> T);
      rsp.degenerate <= gm.degen;
    end
  end

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("request taken while response blocked");

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[T+3] && !dv[T].zero && !dv[T].one |-> dv[T].r < dv[T].len2)
    else $error("divider remainder out of range");

  a_degen_t: assert property (@(posedge clk) disable iff (rst)
    vld[T+3] && dv[T].g.degen |-> t_val == '0)
    else $error("degenerate segment scaled");

endmodule

FILE: bench/tb_nearest_point_on_segment_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_point_on_segment_unit
// Drives segment/query requests through the nearest point unit and compares
// every response against an exact in-bench computation of the clamped
// projection, under random idle and stall on both channels.
// ----------------------------------------------------------------------------

class nearest_scoreboard;
  npos_pkg::rsp_t pending_pts[$];
  int   errors;

  function npos_pkg::rsp_t project(npos_pkg::req_t r);
    logic signed [33:0]  d [3];
    logic signed [33:0]  s [3];
    logic signed [33:0]  q [3];
    logic signed [69:0]  dot;
    logic signed [69:0]  len2;
    logic signed [69:0]  rem;
    logic [16:0]         t;
    logic signed [55:0]  p;
    logic signed [33:0]  v;
    npos_pkg::rsp_t      o;
    logic                degen;
    s[0] = r.start_x; s[1] = r.start_y; s[2] = r.start_z;
    q[0] = r.query_x; q[1] = r.query_y; q[2] = r.query_z;
    d[0] = 34'(r.end_x) - s[0];
    d[1] = 34'(r.end_y) - s[1];
    d[2] = 34'(r.end_z) - s[2];
    dot = 0; len2 = 0; t = 0;
    degen = (d[0] == 0) && (d[1] == 0) && (d[2] == 0);
    for (int a = 0; a < 3; a++) begin
      dot  = dot + 70'(d[a]) * 70'(q[a] - s[a]);
      len2 = len2 + 70'(d[a]) * 70'(d[a]);
    end
    if (!degen && dot > 0) begin
      if (dot >= len2) begin
        t = 17'h10000;
      end else begin
        rem = dot;
        for (int i = 0; i < 16; i++) begin
          rem = rem <<< 1;
          t = t << 1;
          if (rem >= len2) begin
            rem = rem - len2;
            t[0] = 1'b1;
          end
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      p = 56'(d[a]) * $signed({39'd0, t});
      v = s[a] + 34'(p >>> 16);
      if (a == 0) o.nearest_x = v[31:0];
      if (a == 1) o.nearest_y = v[31:0];
      if (a == 2) o.nearest_z = v[31:0];
    end
    o.degenerate = degen;
    return o;
  endfunction

  function void note_request(npos_pkg::req_t r);
    pending_pts.push_back(project(r));
  endfunction

  function void check_response(npos_pkg::rsp_t got);
    npos_pkg::rsp_t want;
    if (pending_pts.size() == 0) begin
      $display("%0t: unexpected response %h", $time, got);
      errors++;
      return;
    end
    want = pending_pts.pop_front();
    if (got.nearest_x !== want.nearest_x)
      $display("%0t: nearest_x exp %h got %h", $time, want.nearest_x, got.nearest_x);
    if (got.nearest_y !== want.nearest_y)
      $display("%0t: nearest_y exp %h got %h", $time, want.nearest_y, got.nearest_y);
    if (got.nearest_z !== want.nearest_z)
      $display("%0t: nearest_z exp %h got %h", $time, want.nearest_z, got.nearest_z);
    if (got.degenerate !== want.degenerate)
      $display("%0t: degenerate exp %b got %b", $time, want.degenerate, got.degenerate);
    if (got !== want) errors++;
  endfunction
endclass

module tb_nearest_point_on_segment_unit;
  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  npos_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  npos_pkg::rsp_t rsp;

  nearest_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  int sent_count;

  nearest_point_on_segment_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 21;
    recv_stall_pct = 71;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
      rsp_stall <= 1'b0;
    end else begin
      if (req_valid && !req_stall) board.note_request(req);
      if (rsp_valid && !rsp_stall) board.check_response(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    wait (quiet_cycles >= 5000);
    $display("FAILURE");
    $finish;
  end

  function automatic npos_pkg::coord_t pick_coord();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return npos_pkg::coord_t'($signed($urandom_range(2000)) - 1000);
      default: return npos_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic send_request(npos_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_random();
    npos_pkg::req_t r;
    r.start_x = pick_coord(); r.start_y = pick_coord(); r.start_z = pick_coord();
    if ($urandom_range(15) == 0) begin
      r.end_x = r.start_x; r.end_y = r.start_y; r.end_z = r.start_z;
    end else begin
      r.end_x = pick_coord(); r.end_y = pick_coord(); r.end_z = pick_coord();
    end
    if ($urandom_range(3) == 0) begin
      r.query_x = r.start_x + ((r.end_x - r.start_x) >>> 1);
      r.query_y = r.start_y + ((r.end_y - r.start_y) >>> 1) + pick_coord() % 64;
      r.query_z = r.start_z + ((r.end_z - r.start_z) >>> 1);
    end else begin
      r.query_x = pick_coord(); r.query_y = pick_coord(); r.query_z = pick_coord();
    end
    send_request(r);
  endtask

  task automatic send_directed();
    npos_pkg::coord_t mx;
    npos_pkg::coord_t mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    // degenerate, behind start, beyond end, midpoint, extremes
    send_request('{5, 6, 7, 5, 6, 7, 100, 200, 300});
    send_request('{mx, mx, mx, mx, mx, mx, mn, mn, mn});
    send_request('{0, 0, 0, 65536, 0, 0, -65536, 0, 0});
    send_request('{0, 0, 0, 65536, 0, 0, 0, 5, 5});
    send_request('{0, 0, 0, 65536, 0, 0, 200000, 0, 0});
    send_request('{0, 0, 0, 65536, 0, 0, 65536, 9, 9});
    send_request('{0, 0, 0, 3, 0, 0, 1, 0, 0});
    send_request('{mn, mn, mn, mx, mx, mx, 0, 0, 0});
    send_request('{mx, mn, mx, mn, mx, mn, 0, 1, -1});
    send_request('{mn, mn, mn, mx, mx, mx, mx, mx, mx});
    send_request('{mn, mn, mn, mx, mx, mx, mn, mn, mn});
    send_request('{mn, 0, 0, mx, 0, 0, 12345, mn, mx});
    send_request('{-1, -1, -1, 1, 1, 1, 0, 0, 0});
    send_request('{0, 0, 0, 0, 0, 1, mx, mx, 0});
    send_request('{0, 0, 0, -7, 11, -13, -3, 5, -6});
  endtask

  initial begin
    sent_count = 0;
    wait (rst === 1'b0);
    @(posedge clk);
    send_directed();
    for (int i = 0; i < 170; i++) send_random();
    send_idle_pct = 71;
    recv_stall_pct = 21;
    for (int i = 0; i < 170; i++) send_random();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 170; i++) send_random();
    req_valid <= 1'b0;
    while (board.pending_pts.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending_pts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
